/* design/cdq_pkg.sv */
`default_nettype none

package cdq_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int CMD_W = 3;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;
  localparam int ST_W  = 2;

  // input word: command, value_in, zero fill to whole bytes
  localparam int IN_BITS  = CMD_W + VAL_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  // output word: status, front_value, rear_value, is_full, is_empty
  localparam int OUT_BITS = ST_W + VAL_W + VAL_W + 1 + 1;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_REAR  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK      = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic load_out;
  } cdq_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } cdq_sts_t;

endpackage

`default_nettype wire

/* design/circular_deque.sv */
// circular_deque: double-ended queue in a circular store
//
// s_* channel takes one command word; m_* channel returns one result word
// for every command, in order. cfg_* writes the capacity (slots in use,
// clamped to 1..DEPTH) and empties the deque; cfg_ready is always high; the
// user must issue a write only while no command is in flight (not enforced).
//
// an accepted command runs through execute (index update and slot write),
// read (both ends addressed on the slot ram) and respond (result built from
// the registered ram data), where the result word is loaded into the output
// register; a new command is taken only after respond is done. the read step
// comes from the registered read port of the slot ram following the slot write.
//
// the result sits in an output register; while the receiver stalls the
// block still takes one more command and holds it at the respond step until
// the output register frees up.
//
// reset empties the deque, sets capacity to 16 and drops m_tvalid; slot
// contents are not cleared, only written slots are ever shown.
`default_nettype none

module circular_deque
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // command word
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,   // command[2:0], value_in[34:3], zero fill
  // result word
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic      [OUT_W-1:0] m_tdata,   // status[1:0], front_value[33:2],
                                           // rear_value[65:34], is_full[66],
                                           // is_empty[67], zero fill
  // capacity register write
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CAP_W-1:0] cfg_data
);

  cdq_ctl_t ctl;
  cdq_sts_t sts;

  assign cfg_ready = 1'b1;

  cdq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .sts     (sts),
    .ctl     (ctl)
  );

  cdq_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .ctl      (ctl),
    .sts      (sts)
  );

endmodule

`default_nettype wire

/* design/cdq_ram.sv */
`default_nettype none

module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

/* design/cdq_ctrl.sv */
`default_nettype none

module cdq_ctrl
  import cdq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  input  wire cdq_sts_t sts,
  output cdq_ctl_t      ctl
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    ctl.capture  = 1'b0;
    ctl.exec     = 1'b0;
    ctl.load_out = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready    = 1'b1;
        ctl.capture = s_tvalid;
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/cdq_dp.sv */
`default_nettype none

module cdq_dp
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [IN_W-1:0]  s_tdata,
  input  wire logic             cfg_valid,
  input  wire logic [CAP_W-1:0] cfg_data,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic      [OUT_W-1:0] m_tdata,
  input  wire cdq_ctl_t         ctl,
  output cdq_sts_t              sts
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int EW    = (IDX_W + 1 > CAP_W) ? IDX_W + 1 : CAP_W;

  logic [CMD_W-1:0] cmd;
  logic [VAL_W-1:0] val;
  logic [CAP_W-1:0] cap;
  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic             empty_f, empty_next;
  logic [ST_W-1:0]  status, status_next;
  logic             out_valid;
  logic [OUT_W-1:0] out_data;

  logic [EW-1:0]    cap_x, depth_x, eff, eff_m1, head_p1, tail_p1;
  logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
  logic             full_now, is_ins, is_del;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [VAL_W-1:0] rd_front, rd_rear, front_v, rear_v;

  // capacity clamped to 1..DEPTH
  always_comb begin
    cap_x   = EW'(cap);
    depth_x = EW'(DEPTH);
    if (cap_x == '0) begin
      eff = EW'(1);
    end else if (cap_x > depth_x) begin
      eff = depth_x;
    end else begin
      eff = cap_x;
    end
    eff_m1   = eff - EW'(1);
    head_p1  = EW'(head) + EW'(1);
    tail_p1  = EW'(tail) + EW'(1);
    head_inc = (head_p1 >= eff) ? '0 : head_p1[IDX_W-1:0];
    tail_inc = (tail_p1 >= eff) ? '0 : tail_p1[IDX_W-1:0];
    head_dec = (head == '0) ? eff_m1[IDX_W-1:0] : head - IDX_W'(1);
    tail_dec = (tail == '0) ? eff_m1[IDX_W-1:0] : tail - IDX_W'(1);
    full_now = !empty_f && (tail_inc == head);
  end

  assign is_ins = (cmd == CMD_INS_FRONT) || (cmd == CMD_INS_REAR);
  assign is_del = (cmd == CMD_DEL_FRONT) || (cmd == CMD_DEL_REAR);

  // index update for one command
  always_comb begin
    head_next   = head;
    tail_next   = tail;
    empty_next  = empty_f;
    status_next = ST_DONE;
    we          = 1'b0;
    waddr       = '0;
    if (is_ins) begin
      if (full_now) begin
        status_next = ST_OVERFLOW;
      end else if (empty_f) begin
        head_next  = '0;
        tail_next  = '0;
        empty_next = 1'b0;
        we         = 1'b1;
      end else if (cmd == CMD_INS_FRONT) begin
        head_next = head_dec;
        we        = 1'b1;
        waddr     = head_dec;
      end else begin
        tail_next = tail_inc;
        we        = 1'b1;
        waddr     = tail_inc;
      end
    end else if (is_del) begin
      if (empty_f) begin
        status_next = ST_UNDERFLOW;
      end else if (head == tail) begin
        head_next  = '0;
        tail_next  = '0;
        empty_next = 1'b1;
      end else if (cmd == CMD_DEL_FRONT) begin
        head_next = head_inc;
      end else begin
        tail_next = tail_dec;
      end
    end
  end

  cdq_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .we     (ctl.exec && we),
    .waddr  (waddr),
    .wdata  (val),
    .raddr_a(head),
    .raddr_b(tail),
    .rdata_a(rd_front),
    .rdata_b(rd_rear)
  );

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd <= s_tdata[CMD_W-1:0];
      val <= s_tdata[CMD_W +: VAL_W];
    end
    if (ctl.exec) begin
      status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap     <= CAP_RESET;
      head    <= '0;
      tail    <= '0;
      empty_f <= 1'b1;
    end else if (cfg_valid) begin
      cap     <= cfg_data;
      head    <= '0;
      tail    <= '0;
      empty_f <= 1'b1;
    end else if (ctl.exec) begin
      head    <= head_next;
      tail    <= tail_next;
      empty_f <= empty_next;
    end
  end

  assign front_v = empty_f ? '1 : rd_front;
  assign rear_v  = empty_f ? '1 : rd_rear;

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_data <= OUT_W'({empty_f, full_now, rear_v, front_v, status});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.out_free = !out_valid || m_tready;
  assign m_tvalid     = out_valid;
  assign m_tdata      = out_data;

endmodule

`default_nettype wire

/* design/cdq_checker.sv */
`default_nettype none

module cdq_checker
  import cdq_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_tvalid,
  input wire logic             s_tready,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata
);

  logic [ST_W-1:0]  st;
  logic [VAL_W-1:0] fv, rv;
  logic             full, empty;

  assign st    = m_tdata[ST_W-1:0];
  assign fv    = m_tdata[ST_W +: VAL_W];
  assign rv    = m_tdata[ST_W + VAL_W +: VAL_W];
  assign full  = m_tdata[ST_W + 2*VAL_W];
  assign empty = m_tdata[ST_W + 2*VAL_W + 1];

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // one command at a time
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("command taken while one is in flight");

  // refused insert means the deque was and stays full
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (st == ST_OVERFLOW) |-> full && !empty)
    else $error("overflow without full deque");

  // empty deque shows all ones at both ends
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && empty |-> (fv == '1) && (rv == '1) && !full)
    else $error("empty deque shows data");

  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

`default_nettype wire
